// ----- rtl/nbr_pkg.sv -----
// ============================================================================
// nbr_pkg
// Shared types, command codes and a clamp helper for the packed nibble raster block.
// ============================================================================
`default_nettype none

package nbr_pkg;

   // Command codes carried in the input item's kind field.
   localparam logic [1:0] FUNC_FILL  = 2'd0;
   localparam logic [1:0] FUNC_GLYPH = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;
   localparam logic [1:0] FUNC_NONE  = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_BASE,
      ST_WALK,
      ST_READ,
      ST_FINISH
   } state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;      // capture the accepted item
      logic setup;     // register clipped bounds and the reject flag
      logic base;      // register the first row address and walk counters
      logic step;      // write one stored byte and advance the walk
      logic rd_en;     // issue the frame store read
      logic out_load;  // move the result into the output register
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic [1:0] func;
      logic       reject;
      logic       walk_last;
      logic       out_free;
   } stat_type;

   // Clamp a signed coordinate into 0..hi.
   function automatic logic signed [16:0] clamp17(input logic signed [16:0] v,
                                                  input logic signed [16:0] hi);
      logic signed [16:0] r;
      if (v < 17'sd0) begin
         r = 17'sd0;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/nbr_ram.sv -----
// ============================================================================
// nbr_ram
// Generic single-port RAM with one write or read per cycle and registered read.
// ============================================================================
`default_nettype none

module nbr_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 76440
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- rtl/nbr_ctrl.sv -----
// ============================================================================
// nbr_ctrl
// Command sequencer: accept, set up, walk the frame store, read, respond.
// ============================================================================
`default_nettype none

module nbr_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire nbr_pkg::stat_type stat,
   output nbr_pkg::cmd_type       cmd
);

   nbr_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nbr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         nbr_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = nbr_pkg::ST_SETUP;
            end
         end
         nbr_pkg::ST_SETUP: begin
            cmd.setup = 1'b1;
            if (stat.reject) begin
               state_in = nbr_pkg::ST_FINISH;
            end else if (stat.func == nbr_pkg::FUNC_READ) begin
               state_in = nbr_pkg::ST_READ;
            end else begin
               state_in = nbr_pkg::ST_BASE;
            end
         end
         nbr_pkg::ST_BASE: begin
            cmd.base = 1'b1;
            state_in = nbr_pkg::ST_WALK;
         end
         nbr_pkg::ST_WALK: begin
            cmd.step = 1'b1;
            if (stat.walk_last) begin
               state_in = nbr_pkg::ST_FINISH;
            end
         end
         nbr_pkg::ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = nbr_pkg::ST_FINISH;
         end
         nbr_pkg::ST_FINISH: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = nbr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = nbr_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/nbr_dp.sv -----
// ============================================================================
// nbr_dp
// Datapath: item capture, clipping, byte walk, nibble stores and output register.
// ============================================================================
`default_nettype none

module nbr_dp #(
   parameter int SCREEN_WIDTH  = 390,
   parameter int SCREEN_HEIGHT = 390
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire nbr_pkg::cmd_type  cmd,
   output nbr_pkg::stat_type      stat,
   input  wire logic [1:0]        req_func,
   input  wire logic [15:0]       req_x_start,
   input  wire logic [15:0]       req_y_start,
   input  wire logic [15:0]       req_x_end,
   input  wire logic [15:0]       req_y_end,
   input  wire logic [3:0]        req_color,
   input  wire logic [15:0]       req_row_bits,
   input  wire logic [16:0]       req_read_address,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [7:0]             rsp_read_data,
   output logic                   rsp_status
);

   localparam int STRIDE      = (SCREEN_WIDTH + 2) / 2;
   localparam int STORE_BYTES = STRIDE * SCREEN_HEIGHT;
   localparam int AW          = $clog2(STORE_BYTES);
   localparam int BW          = $clog2(STRIDE);
   localparam int PW          = BW + 1;
   localparam int YW          = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;

   // Captured item.
   logic [1:0]         func_ff;
   logic signed [15:0] xs_ff, ys_ff, xe_ff, ye_ff;
   logic [3:0]         color_ff;
   logic [15:0]        mask_ff;
   logic [16:0]        addr_ff;

   // Clipped bounds and walk state.
   logic [PW-1:0]      xlo_ff, xhi_ff;
   logic [YW-1:0]      ylo_ff, yhi_ff, y_ff;
   logic [BW-1:0]      bx_ff;
   logic [AW-1:0]      row_base_ff;
   logic               reject_ff;

   // Output register.
   logic               rsp_valid_ff;
   logic [7:0]         rsp_data_ff;
   logic               rsp_status_ff;

   logic signed [16:0] xs17, ys17, xe17, ye17, x15, wmax, hmax;
   logic signed [16:0] xhi_src, yhi_src;
   logic               reject_now;
   logic [AW-1:0]      row_base_in, wr_addr, ram_addr;
   logic [PW-1:0]      p_hi, p_lo;
   logic [3:0]         idx_hi, idx_lo;
   logic               hi_en, lo_en;
   logic [3:0]         hi_rdata, lo_rdata;
   logic               bx_last;

   assign xs17 = {xs_ff[15], xs_ff};
   assign ys17 = {ys_ff[15], ys_ff};
   assign xe17 = {xe_ff[15], xe_ff};
   assign ye17 = {ye_ff[15], ye_ff};
   assign x15  = xs17 + 17'sd15;
   assign wmax = 17'(SCREEN_WIDTH - 1);
   assign hmax = 17'(SCREEN_HEIGHT - 1);

   // A glyph row spans sixteen pixels on one screen row; a fill spans its corners.
   assign xhi_src = (func_ff == nbr_pkg::FUNC_FILL) ? xe17 : x15;
   assign yhi_src = (func_ff == nbr_pkg::FUNC_FILL) ? ye17 : ys17;

   always_comb begin
      case (func_ff)
         nbr_pkg::FUNC_FILL:  reject_now = (xs17 > xe17) || (ys17 > ye17);
         nbr_pkg::FUNC_GLYPH: reject_now = (ys17 < 17'sd0) || (ys17 > hmax) ||
                                           (xs17 > wmax) || (x15 < 17'sd0);
         nbr_pkg::FUNC_READ:  reject_now = 32'(addr_ff) >= 32'(STORE_BYTES);
         default:             reject_now = 1'b1;
      endcase
   end

   // Screen row y lives at byte (SCREEN_HEIGHT-1-y)*STRIDE.
   assign row_base_in = AW'(YW'(SCREEN_HEIGHT - 1) - ylo_ff) * AW'(STRIDE);

   assign bx_last = (bx_ff == xhi_ff[PW-1:1]);
   assign p_hi    = {bx_ff, 1'b0};
   assign p_lo    = {bx_ff, 1'b1};
   assign idx_hi  = 4'(16'(p_hi) - xs_ff);
   assign idx_lo  = 4'(16'(p_lo) - xs_ff);
   assign hi_en   = (p_hi >= xlo_ff) && (p_hi <= xhi_ff) && mask_ff[idx_hi];
   assign lo_en   = (p_lo >= xlo_ff) && (p_lo <= xhi_ff) && mask_ff[idx_lo];

   assign wr_addr  = row_base_ff + AW'(bx_ff);
   assign ram_addr = cmd.step ? wr_addr : AW'(addr_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         xs_ff    <= req_x_start;
         ys_ff    <= req_y_start;
         xe_ff    <= req_x_end;
         ye_ff    <= req_y_end;
         color_ff <= req_color;
         mask_ff  <= (req_func == nbr_pkg::FUNC_FILL) ? 16'hffff : req_row_bits;
         addr_ff  <= req_read_address;
      end
      if (cmd.setup) begin
         xlo_ff    <= PW'(nbr_pkg::clamp17(xs17, wmax));
         xhi_ff    <= PW'(nbr_pkg::clamp17(xhi_src, wmax));
         ylo_ff    <= YW'(nbr_pkg::clamp17(ys17, hmax));
         yhi_ff    <= YW'(nbr_pkg::clamp17(yhi_src, hmax));
         reject_ff <= reject_now;
      end
      if (cmd.base) begin
         row_base_ff <= row_base_in;
         bx_ff       <= xlo_ff[PW-1:1];
         y_ff        <= ylo_ff;
      end else if (cmd.step) begin
         if (bx_last) begin
            bx_ff       <= xlo_ff[PW-1:1];
            y_ff        <= y_ff + YW'(1);
            row_base_ff <= row_base_ff - AW'(STRIDE);
         end else begin
            bx_ff <= bx_ff + BW'(1);
         end
      end
      if (cmd.out_load) begin
         rsp_status_ff <= reject_ff;
         rsp_data_ff   <= (func_ff == nbr_pkg::FUNC_READ && !reject_ff) ?
                          {hi_rdata, lo_rdata} : 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // The left pixel of each byte is the high nibble.
   nbr_ram #(
      .WIDTH (4),
      .DEPTH (STORE_BYTES)
   ) u_hi_ram (
      .clock (clock),
      .we    (cmd.step && hi_en),
      .re    (cmd.rd_en),
      .addr  (ram_addr),
      .wdata (color_ff),
      .rdata (hi_rdata)
   );

   nbr_ram #(
      .WIDTH (4),
      .DEPTH (STORE_BYTES)
   ) u_lo_ram (
      .clock (clock),
      .we    (cmd.step && lo_en),
      .re    (cmd.rd_en),
      .addr  (ram_addr),
      .wdata (color_ff),
      .rdata (lo_rdata)
   );

   assign stat.func      = func_ff;
   assign stat.reject    = reject_now;
   assign stat.walk_last = bx_last && (y_ff == yhi_ff);
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

`default_nettype wire

// ----- rtl/packed_nibble_rect_and_glyph_raster.sv -----
// ============================================================================
// packed_nibble_rect_and_glyph_raster
// Packed 4-bit frame store with rectangle fill, glyph-row draw and byte read.
// ============================================================================
// The block holds a frame of 4-bit pixels, two to a byte with the left pixel in
// the high nibble, rows stored bottom-up at a stride of (SCREEN_WIDTH+2)/2 bytes.
// Each accepted item gives exactly one result item, and none is taken until the
// last is handed to the output register. A fill or glyph item is set up, then
// walks the stored bytes it touches (clipped rows times byte columns), writing
// one byte per cycle through the single port of the frame store. A read is set
// up, then read; a rejected item goes from setup to the hand-off. Results sit
// in an output register, so a finished result waiting on rsp_tready holds back
// only the end of the following item. The frame store is not cleared at reset:
// reading a byte that was never written returns an arbitrary value.
`default_nettype none

module packed_nibble_rect_and_glyph_raster #(
   parameter int SCREEN_WIDTH  = 390,
   parameter int SCREEN_HEIGHT = 390
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // Input items.
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // tdata from bit 0 up: x_start[15:0], y_start[31:16], x_end[47:32],
   // y_end[63:48], color[67:64], row_bits[83:68], read_address[100:84], zeros.
   input  wire logic [103:0] req_tdata,
   // tuser: func[1:0] (0 fill, 1 glyph row, 2 read byte).
   input  wire logic [1:0]   req_tuser,
   // Result items.
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // tdata: read_data[7:0].
   output logic [7:0]        rsp_tdata,
   // tuser: status[0] (0 done, 1 rejected, which includes an off-screen glyph row).
   output logic [0:0]        rsp_tuser
);

   nbr_pkg::cmd_type  cmd;
   nbr_pkg::stat_type stat;

   // The sequencer steps each item through setup, the byte walk or the read,
   // and the hand-off to the output register.
   nbr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // The datapath clips coordinates, walks the byte addresses and owns the
   // two nibble stores, so partial edge bytes need no read-modify-write.
   nbr_dp #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_func         (req_tuser),
      .req_x_start      (req_tdata[15:0]),
      .req_y_start      (req_tdata[31:16]),
      .req_x_end        (req_tdata[47:32]),
      .req_y_end        (req_tdata[63:48]),
      .req_color        (req_tdata[67:64]),
      .req_row_bits     (req_tdata[83:68]),
      .req_read_address (req_tdata[100:84]),
      .rsp_valid        (rsp_tvalid),
      .rsp_ready        (rsp_tready),
      .rsp_read_data    (rsp_tdata),
      .rsp_status       (rsp_tuser[0])
   );

endmodule

`default_nettype wire

// ----- test/packed_nibble_rect_and_glyph_raster_tb.sv -----
// ----------------------------------------------------------------------------
// packed_nibble_rect_and_glyph_raster_tb
// Self-checking bench for the packed 4-bit rectangle and glyph raster.
// ----------------------------------------------------------------------------
// The bench keeps its own copy of the frame store. It updates that copy when
// each command is accepted and queues the one result that the command should
// produce. Read commands only target bytes whose two pixels were both written
// before, because the block's store powers up with arbitrary contents. The run
// opens with a whole-screen fill, which makes almost every byte safe to read.
// A short directed list then covers rejects, clamping and clipping. A long
// random list follows. Both handshakes see random gaps and stalls.
// ----------------------------------------------------------------------------
module packed_nibble_rect_and_glyph_raster_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SCREEN_W    = 390;
   localparam int SCREEN_H    = 390;
   localparam int ROW_BYTES   = (SCREEN_W + 2) / 2;
   localparam int STORE_BYTES = ROW_BYTES * SCREEN_H;
   localparam int ADDR_TOP    = 131071;  // largest value of the 17-bit address field
   localparam int RANDOM_ITEMS = 830;

   // One drawing command, with the coordinates kept as sign-extended integers.
   typedef struct {
      logic [1:0]  func;
      int          xs;
      int          ys;
      int          xe;
      int          ye;
      logic [3:0]  color;
      logic [15:0] mask;
      logic [16:0] addr;
   } draw_cmd_type;

   typedef struct {
      logic [7:0] data;
      logic       status;
   } raster_result_type;

   // Shadow frame store and queue of the results still owed by the block.
   class frame_shadow;
      logic [7:0]        frame_bytes [STORE_BYTES];
      bit   [1:0]        nibble_known [STORE_BYTES];  // bit 1 high nibble, bit 0 low
      raster_result_type owed_results [$];
      int                last_touched;
      int                error_count;

      function void paint(int x, int y, logic [3:0] col);
         int a;
         a = (SCREEN_H - 1 - y) * ROW_BYTES + x / 2;
         if (x % 2 == 0) begin
            frame_bytes[a][7:4] = col;
            nibble_known[a][1] = 1'b1;
         end else begin
            frame_bytes[a][3:0] = col;
            nibble_known[a][0] = 1'b1;
         end
         last_touched = a;
      endfunction

      function int clip(int v, int hi);
         return (v < 0) ? 0 : ((v > hi) ? hi : v);
      endfunction

      function logic fill_rect(int x1, int y1, int x2, int y2, logic [3:0] col);
         int lx, rx, ty, by;
         if (x1 > x2 || y1 > y2) begin
            return 1'b1;
         end
         lx = clip(x1, SCREEN_W - 1);
         rx = clip(x2, SCREEN_W - 1);
         ty = clip(y1, SCREEN_H - 1);
         by = clip(y2, SCREEN_H - 1);
         for (int y = ty; y <= by; y++) begin
            for (int x = lx; x <= rx; x++) begin
               paint(x, y, col);
            end
         end
         return 1'b0;
      endfunction

      function logic draw_glyph_row(int x, int y, logic [15:0] bits, logic [3:0] col);
         if (y < 0 || y >= SCREEN_H || x >= SCREEN_W || x + 15 < 0) begin
            return 1'b1;
         end
         for (int i = 0; i < 16; i++) begin
            if (bits[i] && x + i >= 0 && x + i < SCREEN_W) begin
               paint(x + i, y, col);
            end
         end
         return 1'b0;
      endfunction

      function void note_item(draw_cmd_type c);
         raster_result_type r;
         r.data = 8'h00;
         r.status = 1'b1;
         case (c.func)
            nbr_pkg::FUNC_FILL: begin
               r.status = fill_rect(c.xs, c.ys, c.xe, c.ye, c.color);
            end
            nbr_pkg::FUNC_GLYPH: begin
               r.status = draw_glyph_row(c.xs, c.ys, c.mask, c.color);
            end
            nbr_pkg::FUNC_READ: begin
               if (c.addr < STORE_BYTES) begin
                  r.data = frame_bytes[c.addr];
                  r.status = 1'b0;
               end
            end
            default: begin
            end
         endcase
         owed_results.push_back(r);
      endfunction

      function void report(string what, logic [7:0] want, logic [7:0] got);
         error_count++;
         $display("%0t ns: %s mismatch, expected %02h, actual %02h",
                  $time, what, want, got);
      endfunction

      function void check_result(logic [7:0] data, logic status);
         raster_result_type r;
         if (owed_results.size() == 0) begin
            report("unexpected result item", 8'h00, data);
            return;
         end
         r = owed_results.pop_front();
         if (data !== r.data) begin
            report("read_data", r.data, data);
         end
         if (status !== r.status) begin
            report("status", {7'd0, r.status}, {7'd0, status});
         end
      endfunction

      function bit byte_known(int a);
         return a >= 0 && a < STORE_BYTES && nibble_known[a] == 2'b11;
      endfunction

      function int owed_count();
         return owed_results.size();
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid;
   logic         req_tready;
   // tdata from bit 0 up: x_start, y_start, x_end, y_end, color, row_bits,
   // read_address, zero padding.
   logic [103:0] req_tdata;
   // tuser: func.
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   // tdata: read_data.
   logic [7:0]   rsp_tdata;
   // tuser: status.
   logic [0:0]   rsp_tuser;

   frame_shadow frame_pred = new();
   bit          no_idle = 1'b0;   // set during stretches where neither side pauses
   int          big_fills_left = 3;

   packed_nibble_rect_and_glyph_raster #(
      .SCREEN_WIDTH (SCREEN_W),
      .SCREEN_HEIGHT(SCREEN_H)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always #5 clock = ~clock;

   // Mostly short pauses, now and then a long one, none at all in a burst.
   function automatic int idle_cycles();
      int r;
      if (no_idle) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 96) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic int pixel_addr(int x, int y);
      return (SCREEN_H - 1 - y) * ROW_BYTES + x / 2;
   endfunction

   function automatic int rand16();
      return $urandom_range(0, 65535) - 32768;
   endfunction

   function automatic logic [103:0] pack_req(draw_cmd_type c);
      return {3'b000, c.addr, c.mask, c.color,
              c.ye[15:0], c.xe[15:0], c.ys[15:0], c.xs[15:0]};
   endfunction

   // Every field starts random so that bits a command ignores still toggle.
   function automatic draw_cmd_type random_cmd(logic [1:0] func);
      draw_cmd_type c;
      c.func  = func;
      c.xs    = rand16();
      c.ys    = rand16();
      c.xe    = rand16();
      c.ye    = rand16();
      c.color = 4'($urandom_range(0, 15));
      c.mask  = 16'($urandom_range(0, 65535));
      c.addr  = 17'($urandom_range(0, ADDR_TOP));
      return c;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance
   // with tvalid still high, so the next item can follow without a gap.
   task automatic send_item(input draw_cmd_type c);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pack_req(c);
      req_tuser  <= c.func;
      do @(posedge clock); while (!req_tready);
      frame_pred.note_item(c);
      @(negedge clock);
   endtask

   task automatic send_fill(int xs, int ys, int xe, int ye, logic [3:0] col);
      draw_cmd_type c;
      c = random_cmd(nbr_pkg::FUNC_FILL);
      c.xs = xs;
      c.ys = ys;
      c.xe = xe;
      c.ye = ye;
      c.color = col;
      send_item(c);
   endtask

   task automatic send_glyph(int x, int y, logic [15:0] bits, logic [3:0] col);
      draw_cmd_type c;
      c = random_cmd(nbr_pkg::FUNC_GLYPH);
      c.xs = x;
      c.ys = y;
      c.mask = bits;
      c.color = col;
      send_item(c);
   endtask

   task automatic send_read(int a);
      draw_cmd_type c;
      c = random_cmd(nbr_pkg::FUNC_READ);
      c.addr = 17'(a);
      send_item(c);
   endtask

   // Most fills are small boxes near the screen. The rest are reversed boxes,
   // strips lying wholly off one side (they paint the clamped edge), and a
   // capped number of fully random boxes drawn from the whole 16-bit range.
   task automatic send_random_fill();
      int s, xs, ys, xe, ye;
      s  = $urandom_range(0, 99);
      xs = $urandom_range(0, 409) - 10;
      xe = xs + $urandom_range(0, 24);
      ys = $urandom_range(0, 399) - 5;
      ye = ys + $urandom_range(0, 12);
      if (s >= 70 && s < 80) begin
         if (s == 79) begin
            xs = 32767;
            xe = -32768;
         end else if ($urandom_range(0, 1) == 0) begin
            xe = xs - $urandom_range(1, 500);
         end else begin
            ye = ys - $urandom_range(1, 500);
         end
      end else if (s >= 80 && s < 95) begin
         case ($urandom_range(0, 3))
            0: begin
               xe = -$urandom_range(1, 32768);
               xs = xe - $urandom_range(0, xe + 32768);
            end
            1: begin
               xs = $urandom_range(SCREEN_W, 32767);
               xe = $urandom_range(xs, 32767);
            end
            2: begin
               ye = -$urandom_range(1, 32768);
               ys = ye - $urandom_range(0, ye + 32768);
            end
            default: begin
               ys = $urandom_range(SCREEN_H, 32767);
               ye = $urandom_range(ys, 32767);
            end
         endcase
      end else if (s >= 95 && big_fills_left > 0) begin
         big_fills_left--;
         xs = rand16();
         xe = rand16();
         ys = rand16();
         ye = rand16();
      end
      send_fill(xs, ys, xe, ye, 4'($urandom_range(0, 15)));
   endtask

   task automatic send_random_glyph();
      int x, y, r;
      logic [15:0] bits;
      r = $urandom_range(0, 99);
      if (r < 90) begin
         y = $urandom_range(0, SCREEN_H - 1);
      end else if (r < 95) begin
         y = -$urandom_range(1, 32768);
      end else begin
         y = $urandom_range(SCREEN_H, 32767);
      end
      r = $urandom_range(0, 99);
      if (r < 75) begin
         x = $urandom_range(0, 419) - 25;
      end else if (r < 82) begin
         x = $urandom_range(0, 5) - 18;
      end else if (r < 89) begin
         x = $urandom_range(SCREEN_W - 4, SCREEN_W + 2);
      end else begin
         x = rand16();
      end
      r = $urandom_range(0, 99);
      bits = (r < 80) ? 16'($urandom_range(0, 65535)) : ((r < 90) ? 16'h0000 : 16'hffff);
      send_glyph(x, y, bits, 4'($urandom_range(0, 15)));
   endtask

   // Reads favor the neighborhood of the last pixel drawn, so that recent
   // writes are checked, and fall back to an out-of-range address when no
   // fully written byte turns up.
   task automatic send_random_read();
      int a, tries;
      if ($urandom_range(0, 99) < 12) begin
         a = $urandom_range(STORE_BYTES, ADDR_TOP);
      end else begin
         if ($urandom_range(0, 1) == 0) begin
            a = frame_pred.last_touched + $urandom_range(0, 4) - 2;
         end else begin
            a = $urandom_range(0, STORE_BYTES - 1);
         end
         tries = 0;
         while (!frame_pred.byte_known(a) && tries < 20) begin
            a = $urandom_range(0, STORE_BYTES - 1);
            tries++;
         end
         if (!frame_pred.byte_known(a)) begin
            a = $urandom_range(STORE_BYTES, ADDR_TOP);
         end
      end
      send_read(a);
   endtask

   // Result side: tready changes at the falling edge, with random stalls.
   initial begin
      int stall;
      stall = 0;
      rsp_tready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
               stall = idle_cycles();
            end
         end
      end
   end

   // Results are compared at the rising edge at which they are taken.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         frame_pred.check_result(rsp_tdata, rsp_tuser[0]);
      end
   end

   initial begin
      draw_cmd_type c;
      int k;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = nbr_pkg::FUNC_FILL;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Whole screen at the coordinate extremes; clamping gives every pixel.
      send_fill(-32768, -32768, 32767, 32767, 4'($urandom_range(0, 15)));
      send_read(0);
      send_read(STORE_BYTES - 2);
      // Reversed boxes are rejected without writing.
      send_fill(10, 20, 9, 30, 4'h5);
      send_fill(10, 5, 20, 4, 4'h6);
      // Boxes wholly off screen still paint the clamped edge column or corner.
      send_fill(-200, 10, -100, 20, 4'h7);
      send_fill(500, 400, 32767, 600, 4'h8);
      send_read(pixel_addr(SCREEN_W - 1, SCREEN_H - 1));
      // A single odd pixel, then its even neighbor, then the byte they share.
      send_fill(5, 3, 5, 3, 4'hf);
      send_fill(4, 3, 4, 3, 4'h0);
      send_read(pixel_addr(4, 3));
      // Glyph rows clipped on the left, wholly left, clipped right, wholly right.
      send_glyph(-15, 0, 16'hffff, 4'hc);
      send_read(pixel_addr(0, 0));
      send_glyph(-16, 1, 16'hffff, 4'h3);
      send_glyph(SCREEN_W - 1, SCREEN_H - 1, 16'hffff, 4'h9);
      send_glyph(SCREEN_W, 5, 16'hffff, 4'h2);
      // Rows above and below the screen, an empty mask, and extreme values.
      send_glyph(10, -1, 16'h5a5a, 4'h1);
      send_glyph(10, SCREEN_H, 16'ha5a5, 4'h1);
      send_glyph(100, 200, 16'h0000, 4'he);
      send_glyph(32767, -32768, 16'hffff, 4'hb);
      // Reads past the end of the store, and the unused command code.
      send_read(STORE_BYTES);
      send_read(ADDR_TOP);
      c = random_cmd(nbr_pkg::FUNC_NONE);
      send_item(c);
      send_fill(0, 0, SCREEN_W - 1, 0, 4'ha);
      send_read(pixel_addr(200, 0));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // Now and then switch into or out of a stretch without pauses.
         if (n % 60 == 0) begin
            no_idle = ($urandom_range(0, 99) < 30);
         end
         k = $urandom_range(0, 99);
         if (k < 38) begin
            send_random_fill();
         end else if (k < 66) begin
            send_random_glyph();
         end else if (k < 95) begin
            send_random_read();
         end else begin
            c = random_cmd(nbr_pkg::FUNC_NONE);
            send_item(c);
         end
      end
      req_tvalid <= 1'b0;

      // Let the last results drain, then watch a little longer for strays.
      while (frame_pred.owed_count() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
      if (frame_pred.error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // This timeout lies far beyond the slowest legal run.
   initial begin
      #30_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
